@@ design/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, widths and the lead byte decode for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 31;
    localparam int CNT_W    = 3;
    localparam int CONT_W   = 6;

    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7F;
    localparam logic [CNT_W-1:0]  LEN_STRAY    = 3'd0;
    localparam logic [CNT_W-1:0]  LEN_SINGLE   = 3'd1;

    typedef struct packed {
        logic              hit;
        logic [CP_W-1:0]   code_point;
        logic [CNT_W-1:0]  byte_count;
        logic              stray_lead;
    } utf8d_result_t;

    // sequence length from a lead byte with its top bit set; zero marks a stray
    function automatic logic [CNT_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0] len;
        len = LEN_STRAY;
        case (b) inside
            [8'hC0:8'hDF]: len = 3'd2;
            [8'hE0:8'hEF]: len = 3'd3;
            [8'hF0:8'hF7]: len = 3'd4;
            [8'hF8:8'hFB]: len = 3'd5;
            [8'hFC:8'hFD]: len = 3'd6;
            default:       len = LEN_STRAY;
        endcase
        return len;
    endfunction

endpackage

@@ design/utf8d_core.sv @@
// ----------------------------------------------------------------------------
// utf8d_core
// Sequence state and decode logic: one byte per step, result when complete.
// ----------------------------------------------------------------------------
module utf8d_core
    import utf8d_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [BYTE_W-1:0]   byte_val,
    output utf8d_result_t       result
);

    logic [CP_W-1:0]  accumulator_reg;
    logic [CP_W-1:0]  accumulator_next;
    logic [CNT_W-1:0] bytes_left_reg;
    logic [CNT_W-1:0] bytes_left_next;
    logic [CNT_W-1:0] seq_len_reg;
    logic [CNT_W-1:0] seq_len_next;
    logic [CNT_W-1:0] len;

    always_comb
    begin
        accumulator_next = accumulator_reg;
        bytes_left_next  = bytes_left_reg;
        seq_len_next     = seq_len_reg;
        result           = '0;
        len              = lead_length(byte_val);
        if (bytes_left_reg != '0)
        begin
            // shift in continuation payload
            accumulator_next = {accumulator_reg[CP_W-CONT_W-1:0], byte_val[CONT_W-1:0]};
            bytes_left_next  = bytes_left_reg - CNT_W'(1);
            if (bytes_left_reg == CNT_W'(1))
            begin
                result.hit        = 1'b1;
                result.code_point = accumulator_next;
                result.byte_count = seq_len_reg;
            end
        end
        else if (!byte_val[BYTE_W-1])
        begin
            result.hit        = 1'b1;
            result.code_point = CP_W'(byte_val);
            result.byte_count = LEN_SINGLE;
        end
        else if (len == LEN_STRAY)
        begin
            // pass through raw with flag
            result.hit        = 1'b1;
            result.code_point = CP_W'(byte_val);
            result.byte_count = LEN_SINGLE;
            result.stray_lead = 1'b1;
        end
        else
        begin
            accumulator_next = CP_W'(byte_val & (PAYLOAD_MASK >> len));
            seq_len_next     = len;
            bytes_left_next  = len - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accumulator_reg <= '0;
            bytes_left_reg  <= '0;
            seq_len_reg     <= '0;
        end
        else if (step)
        begin
            accumulator_reg <= accumulator_next;
            bytes_left_reg  <= bytes_left_next;
            seq_len_reg     <= seq_len_next;
        end
    end

endmodule

@@ design/utf8_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-wide UTF-8 decoder with a registered input beat and a registered result.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | sink      | in_valid/in_stall  | byte_in[7:0]
//   out     | source    | out_valid/out_stall| code_point[30:0], byte_count[2:0],
//           |           |                    | stray_lead
//
// One byte is taken every cycle unless in_stall is high; the result of a completing
// byte passes through the input register, then the result register.
// Reset clears both valid flags and the sequence state.
// A held result stalls the input register; in_stall follows out_stall at once,
// so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  byte_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CP_W-1:0]    code_point,
    output logic [CNT_W-1:0]   byte_count,
    output logic               stray_lead
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic [CP_W-1:0]   code_point_reg;
    logic [CNT_W-1:0]  byte_count_reg;
    logic              stray_lead_reg;
    logic              advance;
    logic              step;
    utf8d_result_t     result;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    utf8d_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .byte_val (in_byte_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && result.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.hit)
        begin
            code_point_reg <= result.code_point;
            byte_count_reg <= result.byte_count;
            stray_lead_reg <= result.stray_lead;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = code_point_reg;
    assign byte_count = byte_count_reg;
    assign stray_lead = stray_lead_reg;

endmodule
